// ===== rtl/core/cwfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwfe_pkg: shared types and constants for the crash window fault escalator
// Per-module table entry, result payload, action codes and reset values.
// ----------------------------------------------------------------------------
package cwfe_pkg;

   localparam int NUM_MODULES_DEF = 4;
   localparam int CFG_MODULES     = 4;    // limit/window register sets
   localparam int CFG_IDX_W       = 4;
   localparam int REQ_DATA_W      = 40;   // 34 payload bits, byte padded
   localparam int RSP_DATA_W      = 48;   // 44 payload bits, byte padded

   localparam logic [1:0] STOP_LEVEL = 2'd2;

   // register index map
   localparam logic [CFG_IDX_W-1:0] CSR_LIMIT_M0  = 4'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_WINDOW_M0 = 4'd4;
   localparam logic [CFG_IDX_W-1:0] CSR_END       = 4'd8;

   localparam logic [7:0]  LIMIT_RST_M1 = 8'd3;
   localparam logic [7:0]  LIMIT_RST    = 8'd5;
   localparam logic [31:0] WINDOW_RST   = 32'd7200;

   localparam logic [1:0] ACT_IGNORE      = 2'd0;
   localparam logic [1:0] ACT_RESTART     = 2'd1;
   localparam logic [1:0] ACT_ESC_RESTART = 2'd2;
   localparam logic [1:0] ACT_ESC_STOP    = 2'd3;

   typedef struct packed {
      logic [1:0]  severity;
      logic        start_valid;
      logic [31:0] start;
      logic [7:0]  count;
   } entry_type;

   localparam entry_type ENTRY_RST = '{severity: 2'd0, start_valid: 1'b0,
                                       start: 32'd0, count: 8'd0};

   // first member lands in the highest bits, so action sits at bit 0
   typedef struct packed {
      logic [1:0]  level;
      logic [31:0] uptime;
      logic [7:0]  tally;
      logic [1:0]  action;
   } rsp_type;

endpackage

// ===== rtl/core/cwfe_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwfe_update: per-module crash bookkeeping
// Takes the table entry read for one death report and forms the new entry,
// the write enable and the result payload.
// ----------------------------------------------------------------------------
module cwfe_update (
   input  cwfe_pkg::entry_type entry_i,
   input  logic                in_range_i,
   input  logic [31:0]         now_i,
   input  logic [7:0]          limit_i,
   input  logic [31:0]         window_i,
   output cwfe_pkg::entry_type entry_o,
   output logic                we_o,
   output cwfe_pkg::rsp_type   rsp_o
);
   import cwfe_pkg::*;

   logic [31:0] start;
   logic [31:0] uptime;
   logic        expired;
   logic [7:0]  count_base;
   logic [8:0]  count_next;
   logic        over;
   logic [1:0]  sev_up;

   always_comb begin
      start      = entry_i.start_valid ? entry_i.start : now_i;
      uptime     = now_i - start;               // wraps mod 2^32
      expired    = uptime > window_i;
      count_base = expired ? 8'd0 : entry_i.count;
      count_next = {1'b0, count_base} + 9'd1;
      over       = count_next > {1'b0, limit_i};
      sev_up     = entry_i.severity + 2'd1;

      entry_o             = entry_i;
      entry_o.start_valid = 1'b1;
      entry_o.start       = expired ? now_i : start;
      rsp_o               = '0;
      we_o                = 1'b0;

      if (!in_range_i) begin
         rsp_o = '0;
      end else if (entry_i.severity >= STOP_LEVEL) begin
         rsp_o.tally = entry_i.count;
         rsp_o.level = entry_i.severity;
      end else begin
         we_o = 1'b1;
         if (over) begin
            entry_o.severity = sev_up;
            entry_o.count    = 8'd0;
            rsp_o.action     = (sev_up >= STOP_LEVEL) ? ACT_ESC_STOP : ACT_ESC_RESTART;
         end else begin
            entry_o.count = count_next[7:0];
            rsp_o.action  = ACT_RESTART;
         end
         rsp_o.tally  = entry_o.count;
         rsp_o.uptime = uptime;
         rsp_o.level  = entry_o.severity;
      end
   end

endmodule

// ===== rtl/core/crash_window_fault_escalator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crash_window_fault_escalator: crash window supervisor with fault escalation
// Per-module crash counts, window starts and fault levels live in one table
// memory; each death report is a read, an update and a write-back.
// ----------------------------------------------------------------------------
// Flow: the request and its table read are registered at the request
//   transfer edge; the result register loads when the lookup retires.
// A new request is taken only after the previous lookup (table read, then
//   update/write-back) retires, later while rsp_tready low holds the result.
// Reset: synchronous, active high. Registers return to their defaults, all
//   table entries read as cleared at once through per-entry valid flops.
// ----------------------------------------------------------------------------
module crash_window_fault_escalator #(
   parameter int NUM_MODULES = cwfe_pkg::NUM_MODULES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [1:0] module_index, [33:2] now_seconds, [39:34] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cwfe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result: [1:0] action, [9:2] crash_count_out, [41:10] uptime_out,
   //         [43:42] fault_level_out, [47:44] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cwfe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cwfe_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data
);
   import cwfe_pkg::*;

   localparam int IDX_W = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   // configuration registers
   logic [7:0]  limit_ff  [CFG_MODULES];
   logic [31:0] window_ff [CFG_MODULES];
   logic        csr_xfer;
   logic [CFG_IDX_W-1:0] csr_win_idx;

   // table memory and entry valid flops
   entry_type   mem [NUM_MODULES];
   logic [NUM_MODULES-1:0] ent_vld_ff;

   state_type   state_ff, state_in;
   logic        req_xfer;
   logic [1:0]  req_module;
   logic [31:0] req_now;
   logic        req_in_range;
   logic [IDX_W-1:0] req_addr;

   // captured request and read data
   logic [1:0]       mod_ff;
   logic [IDX_W-1:0] addr_ff;
   logic             in_range_ff;
   logic [31:0]      now_ff;
   entry_type        rd_entry_ff;
   logic             rd_hit_ff;
   entry_type        cur_entry;

   entry_type   new_entry;
   logic        upd_we;
   rsp_type     upd_rsp;
   logic        finish;

   rsp_type     rsp_ff;
   logic        rsp_vld_ff, rsp_vld_in;

   // ---------------------------------------------------------------- csr ---
   assign csr_ready   = 1'b1;
   assign csr_xfer    = csr_valid && csr_ready;
   assign csr_win_idx = csr_index - CSR_WINDOW_M0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_MODULES; i++) begin
            limit_ff[i]  <= (i == 1) ? LIMIT_RST_M1 : LIMIT_RST;
            window_ff[i] <= WINDOW_RST;
         end
      end else if (csr_xfer) begin
         if (csr_index < CSR_WINDOW_M0) begin
            limit_ff[csr_index[1:0]] <= csr_data[7:0];
         end else if (csr_index < CSR_END) begin
            window_ff[csr_win_idx[1:0]] <= csr_data;
         end
      end
   end

   // ------------------------------------------------------------ request ---
   assign req_module   = req_tdata[1:0];
   assign req_now      = req_tdata[33:2];
   assign req_in_range = ({30'd0, req_module} < NUM_MODULES);
   assign req_addr     = req_module[IDX_W-1:0];
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_xfer     = req_tvalid && req_tready;

   // result register free (or draining this cycle) lets the lookup retire
   assign finish = (state_ff == ST_LOOK) && (!rsp_vld_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // synchronous table read, registered with the request; write-back completes before
   // the next request can be taken, so no forwarding path is needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mod_ff      <= req_module;
         addr_ff     <= req_addr;
         in_range_ff <= req_in_range;
         now_ff      <= req_now;
         rd_entry_ff <= mem[req_addr];
         rd_hit_ff   <= ent_vld_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (finish && upd_we) begin
         mem[addr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
      end else if (finish && upd_we) begin
         ent_vld_ff[addr_ff] <= 1'b1;
      end
   end

   assign cur_entry = rd_hit_ff ? rd_entry_ff : ENTRY_RST;

   cwfe_update u_update (
      .entry_i    (cur_entry),
      .in_range_i (in_range_ff),
      .now_i      (now_ff),
      .limit_i    (limit_ff[mod_ff]),
      .window_i   (window_ff[mod_ff]),
      .entry_o    (new_entry),
      .we_o       (upd_we),
      .rsp_o      (upd_rsp)
   );

   // ------------------------------------------------------------- result ---
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;
      if (finish) rsp_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   // --------------------------------------------------------- assertions ---
   a_req_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_LOOK))
      else $error("request transfer did not start a table lookup");

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_vld_ff)
      else $error("finished lookup did not present a result");

   a_stop_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_ff.action == ACT_ESC_STOP)) |->
         (rsp_ff.level == STOP_LEVEL && rsp_ff.tally == 8'd0))
      else $error("stop action without stop fault level and cleared count");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |=> (rsp_vld_ff && $stable(rsp_ff)))
      else $error("result register changed while stalled");

endmodule
